// File: design/epx_pkg.sv
// Shared types, constants and the EPX pixel rule for the 2x upscaler.
// No dependencies; imported by epx_line_ram, epx_pixel_upscaler_2x_top and the testbench.
package epx_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int PIXEL_BITS   = 32;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int WREG_BITS    = COL_BITS + 1;
  localparam int HREG_BITS    = ROW_BITS + 1;
  localparam int CFG_BITS     = HREG_BITS;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WREG_BITS-1:0] WIDTH_RESET  = WREG_BITS'(64);
  localparam logic [HREG_BITS-1:0] HEIGHT_RESET = HREG_BITS'(32);

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  // One column of the line store: the pixel one row up and two rows up.
  typedef struct packed {
    pixel_t above;
    pixel_t above_above;
  } line_entry_t;

  typedef struct packed {
    pixel_t top_left;
    pixel_t top_right;
    pixel_t bottom_left;
    pixel_t bottom_right;
  } quad_t;

  // EPX: center p, neighbors a (above), b (right), l (left), d (below).
  function automatic quad_t epx_rule(pixel_t p, pixel_t a, pixel_t b,
                                     pixel_t l, pixel_t d);
    quad_t q;
    q.top_left     = (l == a && l != d && a != b) ? a : p;
    q.top_right    = (a == b && a != l && b != d) ? b : p;
    q.bottom_left  = (d == l && d != b && l != a) ? l : p;
    q.bottom_right = (b == d && b != a && d != l) ? d : p;
    return q;
  endfunction

endpackage

// File: design/epx_pixel_upscaler_2x_top.sv
// Top level of the EPX 2x pixel upscaler: counters, line-store prefetch,
// item stage and block output register. Depends on epx_pkg and epx_line_ram.
//
//  channel  handshake             payload
//  -------  --------------------  -----------------------------------------
//  pixel    pix_valid/pix_ready   pixel
//  block    blk_valid/blk_ready   top_left, top_right, bottom_left,
//                                 bottom_right, source_col, source_row,
//                                 frame_end
//  config   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One pixel word is taken per cycle when not stalled. Rows other than the
// first and the last give one block word per pixel, the first row none; the
// last row gives up to three (block above, block to the left, and the row-end
// block), and the single output register sends one per cycle while not
// stalled, so those pixels stall the input. Blocks pass the item stage, then
// the output register. After rst the counters sit at column 0, row 0 and the
// registers hold their defaults. Each config write stalls the pixel input
// while the line store prefetch is reloaded. A stalled block output holds the
// item stage and then the pixel input; the config port never stalls.
module epx_pixel_upscaler_2x_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  epx_pkg::pixel_t              pixel,
  output logic                         blk_valid,
  input  logic                         blk_ready,
  output epx_pkg::pixel_t              top_left,
  output epx_pkg::pixel_t              top_right,
  output epx_pkg::pixel_t              bottom_left,
  output epx_pkg::pixel_t              bottom_right,
  output epx_pkg::col_t                source_col,
  output epx_pkg::row_t                source_row,
  output logic                         frame_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [epx_pkg::CFG_BITS-1:0] cfg_data
);
  import epx_pkg::*;

  // Prefetch reload sequencer codes.
  localparam logic [1:0] RF_IDLE = 2'd0;
  localparam logic [1:0] RF_CUR  = 2'd1;
  localparam logic [1:0] RF_NXT  = 2'd2;

  // ---------------- configuration ----------------
  logic [WREG_BITS-1:0] image_width;
  logic [HREG_BITS-1:0] image_height;
  logic [WREG_BITS-1:0] width_eff;
  logic [HREG_BITS-1:0] height_eff;
  logic                 cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WREG_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp: zero acts as one, oversize saturates to the limit.
  always_comb begin
    width_eff = image_width;
    if (image_width == '0) width_eff = WREG_BITS'(1);
    if (image_width > WREG_BITS'(MAX_WIDTH)) width_eff = WREG_BITS'(MAX_WIDTH);
    height_eff = image_height;
    if (image_height == '0) height_eff = HREG_BITS'(1);
    if (image_height > HREG_BITS'(HEIGHT_LIMIT)) height_eff = HREG_BITS'(HEIGHT_LIMIT);
  end

  // ---------------- position and neighbor history ----------------
  col_t        col_count;
  row_t        row_count;
  pixel_t      prev_pixel;     // pixel (c-1, r)
  pixel_t      prev2_pixel;    // pixel (c-2, r)
  pixel_t      prev_above;     // pixel (c-1, r-1)
  line_entry_t line_cur;       // line store entry of column c
  logic        nxt_byp;
  line_entry_t nxt_byp_val;
  line_entry_t rd_data;
  line_entry_t line_nxt;       // line store entry of the next column
  logic [1:0]  rf_state;

  logic        last_col;
  logic        last_row;
  logic        next_last;
  col_t        col_next;
  col_t        col_after;
  logic        pix_fire;
  line_entry_t wr_entry;
  logic        rd_en;
  col_t        rd_addr;

  assign line_nxt  = nxt_byp ? nxt_byp_val : rd_data;
  assign last_col  = ({1'b0, col_count} + WREG_BITS'(1)) >= width_eff;
  assign last_row  = ({1'b0, row_count} + HREG_BITS'(1)) >= height_eff;
  assign col_next  = last_col ? '0 : col_count + COL_BITS'(1);
  assign next_last = ({1'b0, col_next} + WREG_BITS'(1)) >= width_eff;
  assign col_after = next_last ? '0 : col_next + COL_BITS'(1);
  assign pix_fire  = pix_valid & pix_ready;
  assign wr_entry  = '{above: pixel, above_above: line_cur.above};

  // Read the column two ahead on each pixel; reload both entries after config.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = col_after;
    case (rf_state)
      RF_CUR: begin
        rd_en   = 1'b1;
        rd_addr = col_count;
      end
      RF_NXT: begin
        rd_en   = 1'b1;
        rd_addr = col_next;
      end
      default: begin
        rd_en   = pix_fire;
        rd_addr = col_after;
      end
    endcase
  end

  epx_line_ram u_line_ram (
    .clk     (clk),
    .wr_en   (pix_fire),
    .wr_addr (col_count),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      prev_pixel <= '0;
      rf_state   <= RF_IDLE;
      nxt_byp    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        rf_state <= RF_CUR;
      end else begin
        case (rf_state)
          RF_CUR:  rf_state <= RF_NXT;
          RF_NXT:  rf_state <= RF_IDLE;
          default: rf_state <= RF_IDLE;
        endcase
      end
      if (rf_state == RF_CUR) begin
        nxt_byp <= 1'b0;
      end
      if (pix_fire) begin
        prev_pixel <= pixel;
        col_count  <= col_next;
        if (last_col) begin
          row_count <= last_row ? '0 : row_count + ROW_BITS'(1);
        end
        // Narrow rows: the column two ahead is the one written now.
        nxt_byp <= (col_after == col_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_state == RF_NXT) begin
      line_cur <= line_nxt;
    end
    if (pix_fire) begin
      prev2_pixel <= prev_pixel;
      prev_above  <= line_cur.above;
      nxt_byp_val <= wr_entry;
      // Single-column rows: the next column is the one written now.
      line_cur    <= (col_next == col_count) ? wr_entry : line_nxt;
    end
  end

  // ---------------- item stage ----------------
  logic       stg_valid;
  logic [2:0] stg_pend;      // blocks still to send: above, left, row end
  pixel_t     s_px;
  pixel_t     s_above;
  pixel_t     s_above2;
  pixel_t     s_right_above;
  pixel_t     s_prev_above;
  pixel_t     s_prev;
  pixel_t     s_prev2;
  col_t       s_col;
  row_t       s_row;
  logic       s_last_col;
  logic       s_row_ge1;
  logic       s_row_ge2;
  logic       s_col_ge1;
  logic       s_col_ge2;
  logic [2:0] new_pend;

  assign new_pend = {last_row & last_col, last_row & (col_count != '0), row_count != '0};

  // Select the first pending block and gather its neighbors.
  logic [2:0] pend_rest;
  pixel_t     nb_p, nb_a, nb_b, nb_l, nb_d;
  col_t       blk_col;
  row_t       blk_row;
  logic       blk_end;
  quad_t      quad;
  logic       out_load;

  always_comb begin
    pend_rest = stg_pend;
    nb_p      = s_px;
    nb_a      = s_row_ge1 ? s_above : s_px;
    nb_b      = s_px;
    nb_l      = s_col_ge1 ? s_prev : s_px;
    nb_d      = s_px;
    blk_col   = s_col;
    blk_row   = s_row;
    blk_end   = 1'b1;
    if (stg_pend[0]) begin
      // block (c, r-1): this pixel is its lower neighbor
      pend_rest[0] = 1'b0;
      nb_p    = s_above;
      nb_a    = s_row_ge2 ? s_above2 : s_above;
      nb_b    = s_last_col ? s_above : s_right_above;
      nb_l    = s_col_ge1 ? s_prev_above : s_above;
      nb_d    = s_px;
      blk_row = s_row - ROW_BITS'(1);
      blk_end = 1'b0;
    end else if (stg_pend[1]) begin
      // last row, block (c-1, r): this pixel is its right neighbor
      pend_rest[1] = 1'b0;
      nb_p    = s_prev;
      nb_a    = s_row_ge1 ? s_prev_above : s_prev;
      nb_b    = s_px;
      nb_l    = s_col_ge2 ? s_prev2 : s_prev;
      nb_d    = s_prev;
      blk_col = s_col - COL_BITS'(1);
      blk_end = 1'b0;
    end else begin
      pend_rest[2] = 1'b0;
    end
    quad = epx_rule(nb_p, nb_a, nb_b, nb_l, nb_d);
  end

  assign out_load  = stg_valid & (~blk_valid | blk_ready);
  assign pix_ready = (rf_state == RF_IDLE) & (~stg_valid | (out_load & (pend_rest == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg_pend  <= '0;
    end else if (pix_fire) begin
      // Items that give no block never occupy the stage.
      stg_valid <= (new_pend != '0);
      stg_pend  <= new_pend;
    end else if (out_load) begin
      stg_valid <= (pend_rest != '0);
      stg_pend  <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s_px          <= pixel;
      s_above       <= line_cur.above;
      s_above2      <= line_cur.above_above;
      s_right_above <= line_nxt.above;
      s_prev_above  <= prev_above;
      s_prev        <= prev_pixel;
      s_prev2       <= prev2_pixel;
      s_col         <= col_count;
      s_row         <= row_count;
      s_last_col    <= last_col;
      s_row_ge1     <= (row_count != '0);
      s_row_ge2     <= (row_count > ROW_BITS'(1));
      s_col_ge1     <= (col_count != '0);
      s_col_ge2     <= (col_count > COL_BITS'(1));
    end
  end

  // ---------------- block output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (out_load) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_left     <= quad.top_left;
      top_right    <= quad.top_right;
      bottom_left  <= quad.bottom_left;
      bottom_right <= quad.bottom_right;
      source_col   <= blk_col;
      source_row   <= blk_row;
      frame_end    <= blk_end;
    end
  end

endmodule

// File: design/epx_line_ram.sv
// Line store for the EPX upscaler: one entry per column, one write and one
// registered read per cycle. Depends on epx_pkg.
module epx_line_ram (
  input  logic                 clk,
  input  logic                 wr_en,
  input  epx_pkg::col_t        wr_addr,
  input  epx_pkg::line_entry_t wr_data,
  input  logic                 rd_en,
  input  epx_pkg::col_t        rd_addr,
  output epx_pkg::line_entry_t rd_data
);
  import epx_pkg::*;

  line_entry_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/sv/epx_pixel_upscaler_2x_top_tb.sv
// Self-checking testbench for the EPX 2x pixel upscaler top level.
// Depends on epx_pkg and the epx_pixel_upscaler_2x_top RTL, which needs epx_line_ram.
`timescale 1ns / 1ps

module epx_pixel_upscaler_2x_top_tb;
  import epx_pkg::*;

  localparam int RANDOM_PIXELS = 400;
  localparam int DRAIN_CYCLES  = 8;     // quiet time after the last block due has come out
  localparam int LONG_HOLD     = 300;   // long output stall, long enough to back up the input

  // One 2x2 output block together with its source coordinates.
  typedef struct packed {
    pixel_t top_left;
    pixel_t top_right;
    pixel_t bottom_left;
    pixel_t bottom_right;
    col_t   col;
    row_t   row;
    logic   frame_end;
  } block_t;

  // Directed stimulus row. When setup is set, the frame geometry is written
  // first. When typed is set, the block in want replaces the computed one.
  typedef struct {
    bit     setup;
    int     w;
    int     h;
    pixel_t px;
    bit     typed;
    block_t want;
  } stim_row_t;

  // Two 3x3 frames, then two single-pixel frames with both pixel extremes.
  // The first 3x3 center takes its upper-left and lower-right corners from
  // the neighbors; the second one its upper-right and lower-left corners.
  stim_row_t dir_tab [20] = '{
    '{1'b1, 3, 3, 32'h0000_0001, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0005, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0002, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0005, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0009, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0007, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0003, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0007, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0004, 1'b0, '0},
    '{1'b0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0006, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0008, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0002, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0006, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 0, 0, 32'h0000_0008, 1'b0, '0},
    '{1'b0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b1, 1, 1, 32'h0000_0000, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 12'd0, 1'b1}},
    '{1'b0, 0, 0, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0, 12'd0, 1'b1}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  pixel_t              pixel = '0;
  logic                blk_valid;
  logic                blk_ready = 1'b0;
  pixel_t              top_left;
  pixel_t              top_right;
  pixel_t              bottom_left;
  pixel_t              bottom_right;
  col_t                source_col;
  row_t                source_row;
  logic                frame_end;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // Expected block words, oldest first.
  block_t blocks_due [$];
  int     error_count = 0;

  // Shadow of the upscaler state: two line stores, the pixel to the left,
  // the raster position and the two geometry registers.
  pixel_t                 row_up1 [MAX_WIDTH];
  pixel_t                 row_up2 [MAX_WIDTH];
  pixel_t                 left_px = '0;
  int                     col_at = 0;
  int                     row_at = 0;
  logic [WREG_BITS-1:0]   width_reg = WIDTH_RESET;
  logic [HREG_BITS-1:0]   height_reg = HEIGHT_RESET;

  // Sender burst state, palette for pixel draws, long-stall handshake
  // between the stimulus and the receiver process.
  int     burst_left = 0;
  pixel_t palette [3];
  int     hold_req = 0;
  int     hold_done = 0;

  epx_pixel_upscaler_2x_top DUT (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pixel        (pixel),
    .blk_valid    (blk_valid),
    .blk_ready    (blk_ready),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .source_col   (source_col),
    .source_row   (source_row),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Effective geometry: zero acts as one, oversize values clamp to the limit.
  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(height_reg);
  endfunction

  // EPX corner choice for center ctr with neighbors up, rt, lf and dn.
  function automatic block_t epx_quad_of(pixel_t ctr, pixel_t up, pixel_t rt, pixel_t lf,
                                         pixel_t dn, int col, int row, logic fend);
    block_t q;
    q.top_left     = ctr;
    q.top_right    = ctr;
    q.bottom_left  = ctr;
    q.bottom_right = ctr;
    if (lf == up && lf != dn && up != rt) q.top_left = up;
    if (up == rt && up != lf && rt != dn) q.top_right = rt;
    if (dn == lf && dn != rt && lf != up) q.bottom_left = lf;
    if (rt == dn && rt != up && dn != lf) q.bottom_right = dn;
    q.col       = col_t'(col);
    q.row       = row_t'(row);
    q.frame_end = fend;
    return q;
  endfunction

  // Advance the shadow state by one source pixel and queue the blocks it
  // releases: the block above first, then on the last row the block to the
  // left, then the row-end block.
  function automatic void upscale_pixel(pixel_t px);
    int     w, h, c, r;
    bit     last_col, last_row;
    pixel_t old2, old1, ctr, up, rt, lf;
    w = active_width();
    h = active_height();
    c = (col_at >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_at;
    r = row_at;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    old2 = row_up2[c];
    old1 = row_up1[c];
    if (r >= 1) begin
      ctr = old1;
      up  = (r >= 2) ? old2 : ctr;
      rt  = last_col ? ctr : row_up1[c + 1];
      lf  = (c >= 1) ? row_up2[c - 1] : ctr;
      blocks_due.push_back(epx_quad_of(ctr, up, rt, lf, px, c, r - 1, 1'b0));
    end
    row_up2[c] = old1;
    row_up1[c] = px;
    if (last_row) begin
      if (c >= 1) begin
        up = (r >= 1) ? row_up2[c - 1] : left_px;
        lf = (c >= 2) ? row_up1[c - 2] : left_px;
        blocks_due.push_back(epx_quad_of(left_px, up, px, lf, left_px, c - 1, r, 1'b0));
      end
      if (last_col) begin
        up = (r >= 1) ? old1 : px;
        lf = (c >= 1) ? left_px : px;
        blocks_due.push_back(epx_quad_of(px, up, px, lf, px, c, r, 1'b1));
      end
    end
    left_px = px;
    if (last_col) begin
      col_at = 0;
      row_at = last_row ? 0 : r + 1;
    end else begin
      col_at = c + 1;
    end
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got_v, want_v);
    error_count++;
    $display("%0t ns: ERROR %s: got %h, want %h", $time, what, got_v, want_v);
  endtask

  task automatic check_block(input block_t got, input block_t want);
    string at;
    at = $sformatf("block (%0d,%0d)", want.col, want.row);
    if (got.top_left !== want.top_left)
      flag_error({at, " top_left"}, got.top_left, want.top_left);
    if (got.top_right !== want.top_right)
      flag_error({at, " top_right"}, got.top_right, want.top_right);
    if (got.bottom_left !== want.bottom_left)
      flag_error({at, " bottom_left"}, got.bottom_left, want.bottom_left);
    if (got.bottom_right !== want.bottom_right)
      flag_error({at, " bottom_right"}, got.bottom_right, want.bottom_right);
    if (got.col !== want.col)
      flag_error({at, " source_col"}, 32'(got.col), 32'(want.col));
    if (got.row !== want.row)
      flag_error({at, " source_row"}, 32'(got.row), 32'(want.row));
    if (got.frame_end !== want.frame_end)
      flag_error({at, " frame_end"}, 32'(got.frame_end), 32'(want.frame_end));
  endtask

  // Offer one pixel word and hold it until accepted. Bursts of random length
  // are separated by random gaps; a zero gap keeps valid high across bursts.
  task automatic push_pixel(input pixel_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_valid <= 1'b1;
    pixel     <= px;
    do @(posedge clk); while (!pix_ready);
  endtask

  // Drop the pixel valid, wait until every block due has come out, then
  // let the pipeline go quiet for the drain time.
  task automatic settle();
    pix_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; valid stays high so back-to-back writes need no
  // second assignment in one step. The caller drops it.
  task automatic write_reg(input logic idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IMAGE_WIDTH) width_reg = WREG_BITS'(val);
    else height_reg = HREG_BITS'(val);
  endtask

  // Change geometry between frames only; a negative value leaves that
  // register alone.
  task automatic set_geometry(input int wv, input int hv);
    settle();
    if (wv >= 0) write_reg(CFG_IMAGE_WIDTH, wv);
    if (hv >= 0) write_reg(CFG_IMAGE_HEIGHT, hv);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a small palette so neighbors often match, plus full random words
  // and the two extremes.
  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 9))
      7:       return pixel_t'($urandom);
      8:       return '0;
      9:       return '1;
      default: return palette[$urandom_range(0, 2)];
    endcase
  endfunction

  function automatic void refill_palette();
    foreach (palette[i]) palette[i] = pixel_t'($urandom);
  endfunction

  // Stream one whole frame at the current geometry through the block.
  task automatic stream_frame();
    int     total;
    pixel_t px;
    total = active_width() * active_height();
    repeat (total) begin
      px = pick_pixel();
      push_pixel(px);
      upscale_pixel(px);
    end
  endtask

  function automatic int draw_width();
    if ($urandom_range(0, 9) == 0) return 0;
    if ($urandom_range(0, 4) == 0) return $urandom_range(9, 24);
    return $urandom_range(1, 8);
  endfunction

  function automatic int draw_height();
    if ($urandom_range(0, 9) == 0) return 0;
    if ($urandom_range(0, 4) == 0) return $urandom_range(7, 12);
    return $urandom_range(1, 6);
  endfunction

  // Check every accepted block word against the oldest one due.
  always @(posedge clk) begin
    block_t got;
    if (!rst && blk_valid && blk_ready) begin
      got = '{top_left, top_right, bottom_left, bottom_right,
              source_col, source_row, frame_end};
      if (blocks_due.size() == 0) flag_error("block word with none due", top_left, '0);
      else check_block(got, blocks_due.pop_front());
    end
  end

  // Receiver: stretches of always-ready, random ready and periodic ready,
  // plus a long hold whenever the stimulus asks for one.
  initial begin : block_sink
    int mode, stretch, period, phase;
    mode    = 0;
    stretch = 0;
    period  = 2;
    phase   = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done++;
        blk_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(10, 80);
          period  = $urandom_range(2, 4);
        end
        stretch--;
        phase = (phase + 1) % period;
        case (mode)
          0:       blk_ready <= 1'b1;
          1:       blk_ready <= ($urandom_range(0, 9) < 6);
          default: blk_ready <= (phase == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int n0, rand_count, frame_no;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames: typed rows replace the computed block with a literal.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].setup) set_geometry(dir_tab[i].w, dir_tab[i].h);
      push_pixel(dir_tab[i].px);
      n0 = blocks_due.size();
      upscale_pixel(dir_tab[i].px);
      if (dir_tab[i].typed) begin
        while (blocks_due.size() > n0) void'(blocks_due.pop_back());
        blocks_due.push_back(dir_tab[i].want);
      end
    end

    // Random frames of small geometry; sometimes only one register changes.
    rand_count = 0;
    frame_no   = 0;
    while (rand_count < RANDOM_PIXELS) begin
      if (frame_no == 1) begin
        // Back up the block: stall the output while a full frame streams in.
        set_geometry(8, 6);
        hold_req++;
      end else begin
        case ($urandom_range(0, 5))
          0:       set_geometry(draw_width(), -1);
          1:       set_geometry(-1, draw_height());
          2:       ;
          default: set_geometry(draw_width(), draw_height());
        endcase
      end
      refill_palette();
      rand_count += active_width() * active_height();
      stream_frame();
      frame_no++;
    end

    // Geometry extremes: zero width and height act as one; a width word
    // wider than the register keeps only its low bits.
    set_geometry(0, 0);
    refill_palette();
    stream_frame();
    set_geometry(2049, 3);
    refill_palette();
    stream_frame();

    settle();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
